>>> rtl/mfbp_pkg.sv
// ----------------------------------------------------------------------------
// mfbp_pkg: shared definitions for the MSB-first bit packer
// Widths, op codes and the job record that passes from the front end to the
// back end through the job queue.
// ----------------------------------------------------------------------------
package mfbp_pkg;

    // Field and state widths.
    localparam int MAX_CODE_LEN = 24;
    localparam int COUNT_BITS   = 24;
    localparam int OP_W         = 2;
    localparam int CODE_W       = 24;
    localparam int LEN_W        = 5;
    localparam int BYTE_W       = 8;
    localparam int BUF_W        = 32;
    localparam int FILL_W       = 3;
    localparam int SHAMT_W      = 6;
    localparam int NBYTES_W     = 2;
    localparam int BYTE_COUNT_W = 24;
    localparam int BIT_COUNT_W  = 27;

    // Job queue depth.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_ALIGN = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // One classified item: the bytes to emit sit at the top of word.
    typedef struct packed {
        logic [BUF_W-1:0]       word;
        logic [NBYTES_W-1:0]    nbytes;
        logic [COUNT_BITS-1:0]  base;
        logic [BIT_COUNT_W-1:0] bits;
    } job_t;

endpackage

>>> rtl/mfbp_cmd_if.sv
// ----------------------------------------------------------------------------
// mfbp_cmd_if: command channel of the bit packer
// Carries one op with its code and length per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mfbp_cmd_if;

    logic                           valid;
    logic                           ready;
    logic [mfbp_pkg::OP_W-1:0]      op;
    logic [mfbp_pkg::CODE_W-1:0]    code;
    logic [mfbp_pkg::LEN_W-1:0]     length;

    modport source (output valid, output op, output code, output length, input ready);
    modport sink   (input valid, input op, input code, input length, output ready);

endinterface

>>> rtl/mfbp_res_if.sv
// ----------------------------------------------------------------------------
// mfbp_res_if: result channel of the bit packer
// Carries one stream byte with its running counts per result.
// ----------------------------------------------------------------------------
interface mfbp_res_if;

    logic                                valid;
    logic                                ready;
    logic [mfbp_pkg::BYTE_W-1:0]         out_byte;
    logic                                byte_valid;
    logic                                last;
    logic [mfbp_pkg::BYTE_COUNT_W-1:0]   byte_count;
    logic [mfbp_pkg::BIT_COUNT_W-1:0]    bit_count;

    modport source (
        output valid, output out_byte, output byte_valid, output last,
        output byte_count, output bit_count, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input last,
        input byte_count, input bit_count, output ready
    );

endinterface

>>> rtl/msb_first_bit_packer.sv
// Path: the first result of an item passes through the job queue and then
// the output register; further results of the same item follow one per cycle
// while the output is taken. Throughput: each item gives one result per byte
// it emits, up to three, or a single empty result, one per cycle while the
// output is taken; a two-entry job queue lets items in meanwhile. Reset
// (rst_n low, asynchronous) clears the pending bits, the counters, the job
// queue and the output register.
// ----------------------------------------------------------------------------
// msb_first_bit_packer: MSB-first variable-length bit writer
// Appends codes of up to 24 bits below the pending bits and emits every
// complete byte, with byte-align, state clear and running byte/bit counts.
// ----------------------------------------------------------------------------
module msb_first_bit_packer (
    input  logic        clk,
    input  logic        rst_n,
    mfbp_cmd_if.sink    cmd,
    mfbp_res_if.source  result
);

    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_valid;
    mfbp_pkg::job_t    wr_job;
    mfbp_pkg::job_t    head;

    // Front end: applies each item to the bit buffer.
    mfbp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_full (q_full),
        .push   (push),
        .job    (wr_job)
    );

    // Job queue between the two ends.
    mfbp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_job  (wr_job),
        .full    (q_full),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop)
    );

    // Back end: emits the results of each job.
    mfbp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop),
        .result  (result)
    );

endmodule

>>> rtl/mfbp_front.sv
// ----------------------------------------------------------------------------
// mfbp_front: command front end
// Owns the pending bit buffer and the byte counter. Each accepted item is
// applied to the state as it is accepted and turned into a job that names the
// bytes to emit and the counts that go with them.
// ----------------------------------------------------------------------------
module mfbp_front (
    input  logic              clk,
    input  logic              rst_n,
    mfbp_cmd_if.sink          cmd,
    input  logic              q_full,
    output logic              push,
    output mfbp_pkg::job_t    job
);

    logic [mfbp_pkg::BUF_W-1:0]      pend_reg, pend_next;
    logic [mfbp_pkg::FILL_W-1:0]     fill_reg, fill_next;
    logic [mfbp_pkg::COUNT_BITS-1:0] count_reg, count_next;

    logic [mfbp_pkg::LEN_W-1:0]      len_sat;
    logic [mfbp_pkg::CODE_W-1:0]     code_mask;
    logic [mfbp_pkg::CODE_W-1:0]     code_m;
    logic [mfbp_pkg::SHAMT_W-1:0]    shamt;
    logic [mfbp_pkg::BUF_W-1:0]      appended;
    logic [mfbp_pkg::LEN_W-1:0]      total;
    logic [mfbp_pkg::NBYTES_W-1:0]   nbytes;
    logic [mfbp_pkg::BUF_W-1:0]      word;
    logic                            clear;

    // Accept whenever the job queue has room.
    assign cmd.ready = !q_full;
    assign push      = cmd.valid && !q_full;

    // Saturate the length, mask the code and place it below the pending bits.
    always_comb
    begin
        len_sat   = (cmd.length > mfbp_pkg::LEN_W'(mfbp_pkg::MAX_CODE_LEN))
                  ? mfbp_pkg::LEN_W'(mfbp_pkg::MAX_CODE_LEN) : cmd.length;
        code_mask = ~({mfbp_pkg::CODE_W{1'b1}} << len_sat);
        code_m    = cmd.code & code_mask;
        shamt     = mfbp_pkg::SHAMT_W'(mfbp_pkg::BUF_W)
                  - mfbp_pkg::SHAMT_W'(len_sat) - mfbp_pkg::SHAMT_W'(fill_reg);
        appended  = pend_reg | (mfbp_pkg::BUF_W'(code_m) << shamt);
        total     = mfbp_pkg::LEN_W'(fill_reg) + len_sat;
    end

    // Classify the op: bytes to emit and the state left behind.
    always_comb
    begin
        pend_next = pend_reg;
        fill_next = fill_reg;
        nbytes    = '0;
        word      = pend_reg;
        clear     = 1'b0;
        unique case (cmd.op)
            mfbp_pkg::OP_WRITE:
            begin
                word      = appended;
                nbytes    = total[mfbp_pkg::LEN_W-1:mfbp_pkg::FILL_W];
                pend_next = appended << {nbytes, 3'b000};
                fill_next = total[mfbp_pkg::FILL_W-1:0];
            end
            mfbp_pkg::OP_ALIGN:
            begin
                if (fill_reg != '0)
                begin
                    nbytes    = mfbp_pkg::NBYTES_W'(1);
                    pend_next = pend_reg << mfbp_pkg::BYTE_W;
                    fill_next = '0;
                end
            end
            mfbp_pkg::OP_CLEAR:
            begin
                pend_next = '0;
                fill_next = '0;
                clear     = 1'b1;
            end
            default:
            begin
                // No operation: state kept, one empty result follows.
            end
        endcase
        count_next = clear ? '0 : count_reg + mfbp_pkg::COUNT_BITS'(nbytes);
    end

    // Job record: the bit count is the same for every result of one item.
    always_comb
    begin
        job.word   = word;
        job.nbytes = nbytes;
        job.base   = clear ? '0 : count_reg;
        job.bits   = mfbp_pkg::BIT_COUNT_W'({count_next, 3'b000})
                   + mfbp_pkg::BIT_COUNT_W'(fill_next);
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else if (push)
        begin
            pend_reg  <= pend_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/mfbp_queue.sv
// ----------------------------------------------------------------------------
// mfbp_queue: job queue
// A short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module mfbp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mfbp_pkg::job_t    wr_job,
    output logic              full,
    output logic              q_valid,
    output mfbp_pkg::job_t    head,
    input  logic              pop
);

    mfbp_pkg::job_t                  slot_reg [mfbp_pkg::QUEUE_DEPTH];
    logic [mfbp_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [mfbp_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;

    assign full    = (cnt_reg == mfbp_pkg::QCNT_W'(mfbp_pkg::QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + mfbp_pkg::QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - mfbp_pkg::QCNT_W'(1);
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == mfbp_pkg::QPTR_W'(mfbp_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + mfbp_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == mfbp_pkg::QPTR_W'(mfbp_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + mfbp_pkg::QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

>>> rtl/mfbp_back.sv
// ----------------------------------------------------------------------------
// mfbp_back: result back end
// Walks the bytes of the job at the head of the queue, one per cycle while the
// output is taken, into the output register, and marks the final result of each item.
// ----------------------------------------------------------------------------
module mfbp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  mfbp_pkg::job_t    head,
    output logic              pop,
    mfbp_res_if.source        result
);

    logic [mfbp_pkg::NBYTES_W-1:0]     idx_reg;
    logic                              valid_reg;
    logic [mfbp_pkg::BYTE_W-1:0]       byte_reg;
    logic                              byte_valid_reg;
    logic                              last_reg;
    logic [mfbp_pkg::BYTE_COUNT_W-1:0] byte_count_reg;
    logic [mfbp_pkg::BIT_COUNT_W-1:0]  bit_count_reg;

    logic                              free;
    logic                              step;
    logic                              is_last;
    logic                              has_byte;
    logic [mfbp_pkg::BUF_W-1:0]        shifted;
    logic [mfbp_pkg::COUNT_BITS-1:0]   cnt_sel;

    // Load the output register when it is empty or being taken.
    assign free    = !valid_reg || result.ready;
    assign step    = q_valid && free;
    assign has_byte = (head.nbytes != '0);
    assign is_last = !has_byte || (idx_reg == head.nbytes - mfbp_pkg::NBYTES_W'(1));
    assign pop     = step && is_last;

    // Select the current byte and its running count.
    always_comb
    begin
        shifted = head.word << {idx_reg, 3'b000};
        cnt_sel = has_byte
                ? head.base + mfbp_pkg::COUNT_BITS'(idx_reg) + mfbp_pkg::COUNT_BITS'(1)
                : head.base;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (step)
                valid_reg <= 1'b1;
            else if (result.ready)
                valid_reg <= 1'b0;
            if (step)
                idx_reg <= is_last ? '0 : idx_reg + mfbp_pkg::NBYTES_W'(1);
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            byte_reg       <= has_byte ? shifted[mfbp_pkg::BUF_W-1 -: mfbp_pkg::BYTE_W] : '0;
            byte_valid_reg <= has_byte;
            last_reg       <= is_last;
            byte_count_reg <= mfbp_pkg::BYTE_COUNT_W'(cnt_sel);
            bit_count_reg  <= head.bits;
        end
    end

    assign result.valid      = valid_reg;
    assign result.out_byte   = byte_reg;
    assign result.byte_valid = byte_valid_reg;
    assign result.last       = last_reg;
    assign result.byte_count = byte_count_reg;
    assign result.bit_count  = bit_count_reg;

    // An empty result is always the only one of its item and carries a zero byte.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.byte_valid |-> result.last && result.out_byte == '0)
        else $error("empty result not marked last or byte not zero");

    // Mid-item, the job being walked is still at the queue head.
    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != '0 |-> q_valid && idx_reg < head.nbytes)
        else $error("byte index outside the current job");

    // The results of one item follow back to back with rising byte counts.
    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && !result.last |=>
            result.valid
            && result.byte_count == $past(result.byte_count) + mfbp_pkg::BYTE_COUNT_W'(1))
        else $error("byte count did not advance within an item");

endmodule
